// ===== rtl/tde_pkg.sv =====
// ----------------------------------------------------------------------------
// tde_pkg
// shared types, sizes and codes for the tile dedupe flip encoder
// ----------------------------------------------------------------------------
package tde_pkg;

    localparam int STORE_TILES = 512;
    localparam int TILE_ROWS   = 8;
    localparam int ADDR_W      = $clog2(STORE_TILES);
    localparam int CNT_W       = $clog2(STORE_TILES + 1);
    localparam int IDX_W       = CNT_W + 1;
    localparam int ROW_W       = $clog2(TILE_ROWS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEDUPE_OFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NO_FLIP_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NO_FLIP_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NO_FLIP_XY  = 3'd5;

    // flip codes, placed at attribute bits 6..5
    localparam logic [1:0] FLIP_NONE = 2'd0;
    localparam logic [1:0] FLIP_X    = 2'd1;
    localparam logic [1:0] FLIP_Y    = 2'd2;
    localparam logic [1:0] FLIP_XY   = 2'd3;

    typedef logic [TILE_ROWS-1:0][15:0] t_tile;

    typedef struct packed {
        t_tile      tile;
        logic [2:0] pal;
        logic       fin;
    } t_job;

    typedef struct packed {
        logic [8:0] tile_offset;
        logic       object_mode;
        logic       dedupe_off;
        logic       no_flip_x;
        logic       no_flip_y;
        logic       no_flip_xy;
    } t_cfg;

    typedef struct packed {
        logic [7:0] map_entry;
        logic [7:0] attribute;
        logic [7:0] plane_low;
        logic [7:0] plane_high;
        logic       new_tile;
        logic       skipped;
        logic       status;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_MATCH,
        K_SKIP,
        K_FULL,
        K_NEW
    } t_kind;

    // reverse the order of the eight 2-bit pixels of a row
    function automatic logic [15:0] mirror_row(input logic [15:0] r);
        logic [15:0] o;
        o = '0;
        for (int p = 0; p < 8; p++) begin
            o[2*(7-p) +: 2] = r[2*p +: 2];
        end
        return o;
    endfunction

endpackage

// ===== rtl/tde_front.sv =====
// ----------------------------------------------------------------------------
// tde_front
// collects rows into a tile and hands finished tiles to the job queue
// ----------------------------------------------------------------------------
module tde_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [15:0]       i_row_pixels,
    input  logic [2:0]        i_palette_slot,
    input  logic              i_last_tile,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_q_push,
    output tde_pkg::t_job     o_q_job
);

    logic [tde_pkg::ROW_W-1:0] r_row, n_row;
    tde_pkg::t_tile            r_rows;
    logic                      w_last_row;
    logic                      w_take;

    assign w_last_row = (r_row == tde_pkg::ROW_W'(tde_pkg::TILE_ROWS - 1));
    assign o_full     = w_last_row && i_q_full;
    assign w_take     = i_push && !o_full;
    assign o_q_push   = w_take && w_last_row;

    always_comb begin
        o_q_job.tile = r_rows;
        o_q_job.tile[tde_pkg::TILE_ROWS-1] = i_row_pixels;
        o_q_job.pal  = i_palette_slot;
        o_q_job.fin  = i_last_tile;
    end

    always_comb begin
        n_row = r_row;
        if (w_take) begin
            n_row = w_last_row ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    // row storage
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rows[r_row] <= i_row_pixels;
        end
    end

endmodule

// ===== rtl/tde_jobq.sv =====
// ----------------------------------------------------------------------------
// tde_jobq
// two-entry queue of finished tiles between front and back
// ----------------------------------------------------------------------------
module tde_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tde_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tde_pkg::t_job o_job
);

    tde_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/tde_back.sv =====
// ----------------------------------------------------------------------------
// tde_back
// searches the tile store, stores new tiles and emits results
// ----------------------------------------------------------------------------
module tde_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tde_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  tde_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_res_valid,
    output tde_pkg::t_res o_res
);

    tde_pkg::t_state             r_state, n_state;
    tde_pkg::t_kind              r_kind;
    tde_pkg::t_tile              r_tile;
    logic [2:0]                  r_pal;
    logic                        r_fin;
    logic [tde_pkg::CNT_W-1:0]   r_count;
    logic [tde_pkg::CNT_W-1:0]   r_issue;
    logic [tde_pkg::CNT_W-1:0]   r_pend_idx;
    logic [tde_pkg::CNT_W-1:0]   r_match_j;
    logic                        r_pend;
    logic                        r_found;
    logic [1:0]                  r_flip;
    logic [tde_pkg::IDX_W-1:0]   r_idx;
    logic [tde_pkg::ROW_W-1:0]   r_row;
    tde_pkg::t_tile              r_rdata;
    tde_pkg::t_tile              mem [tde_pkg::STORE_TILES];

    tde_pkg::t_tile              w_xf, w_yf, w_xyf;
    logic                        w_eq0, w_eqx, w_eqy, w_eqxy, w_hit;
    logic [1:0]                  w_hit_flip;
    logic                        w_rd_en;
    logic                        w_scan_done;
    logic                        w_slot_free;
    logic                        w_load;
    logic                        w_out_end;
    logic [tde_pkg::IDX_W-1:0]   w_idx_hit, w_idx_new;
    logic                        w_room;
    logic [15:0]                 w_row;
    tde_pkg::t_res               w_res;

    // flipped versions of the tile under search
    always_comb begin
        for (int r = 0; r < tde_pkg::TILE_ROWS; r++) begin
            w_xf[r]  = tde_pkg::mirror_row(r_tile[r]);
            w_yf[r]  = r_tile[tde_pkg::TILE_ROWS-1-r];
            w_xyf[r] = tde_pkg::mirror_row(r_tile[tde_pkg::TILE_ROWS-1-r]);
        end
    end

    assign w_eq0  = (r_rdata == r_tile);
    assign w_eqx  = (r_rdata == w_xf)  && !i_cfg.no_flip_x;
    assign w_eqy  = (r_rdata == w_yf)  && !i_cfg.no_flip_y;
    assign w_eqxy = (r_rdata == w_xyf) && !i_cfg.no_flip_xy;
    assign w_hit  = r_pend && (w_eq0 || w_eqx || w_eqy || w_eqxy);

    always_comb begin
        if (w_eq0) begin
            w_hit_flip = tde_pkg::FLIP_NONE;
        end else if (w_eqx) begin
            w_hit_flip = tde_pkg::FLIP_X;
        end else if (w_eqy) begin
            w_hit_flip = tde_pkg::FLIP_Y;
        end else begin
            w_hit_flip = tde_pkg::FLIP_XY;
        end
    end

    assign w_rd_en     = (r_state == tde_pkg::S_SCAN) && (r_issue < r_count) && !w_hit;
    assign w_scan_done = !r_pend && (r_issue == r_count);
    assign w_idx_hit   = tde_pkg::IDX_W'(r_match_j) + tde_pkg::IDX_W'(i_cfg.tile_offset);
    assign w_idx_new   = tde_pkg::IDX_W'(r_count) + tde_pkg::IDX_W'(i_cfg.tile_offset);
    assign w_room      = (w_idx_new < tde_pkg::IDX_W'(tde_pkg::STORE_TILES));

    assign w_slot_free = !o_res_valid || i_pop;
    assign w_load      = (r_state == tde_pkg::S_OUT) && w_slot_free;
    assign w_out_end   = (r_kind != tde_pkg::K_NEW) ||
                         (r_row == tde_pkg::ROW_W'(tde_pkg::TILE_ROWS - 1));
    assign o_job_pop   = (r_state == tde_pkg::S_IDLE) && i_job_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tde_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    n_state = tde_pkg::S_CLASS;
                end
            end
            tde_pkg::S_CLASS: begin
                if (i_cfg.object_mode && (r_tile == '0)) begin
                    n_state = tde_pkg::S_OUT;
                end else if (i_cfg.dedupe_off) begin
                    n_state = tde_pkg::S_DECIDE;
                end else begin
                    n_state = tde_pkg::S_SCAN;
                end
            end
            tde_pkg::S_SCAN: begin
                if (w_hit || w_scan_done) begin
                    n_state = tde_pkg::S_DECIDE;
                end
            end
            tde_pkg::S_DECIDE: begin
                n_state = tde_pkg::S_OUT;
            end
            tde_pkg::S_OUT: begin
                if (w_slot_free && w_out_end) begin
                    n_state = tde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tde_pkg::S_IDLE;
            end
        endcase
    end

    // result for the current output step
    always_comb begin
        w_row = r_tile[r_row];
        w_res = '0;
        w_res.last = w_out_end;
        case (r_kind)
            tde_pkg::K_SKIP: begin
                w_res.skipped = 1'b1;
            end
            tde_pkg::K_FULL: begin
                w_res.status = 1'b1;
            end
            tde_pkg::K_MATCH: begin
                w_res.map_entry = r_idx[7:0];
                w_res.attribute = {1'b0, r_flip, i_cfg.object_mode, r_idx[8], r_pal};
            end
            tde_pkg::K_NEW: begin
                w_res.map_entry = r_idx[7:0];
                w_res.attribute = {1'b0, tde_pkg::FLIP_NONE, i_cfg.object_mode,
                                   r_idx[8], r_pal};
                w_res.new_tile  = 1'b1;
                for (int p = 0; p < 8; p++) begin
                    w_res.plane_low[7-p]  = w_row[14-2*p];
                    w_res.plane_high[7-p] = w_row[15-2*p];
                end
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tde_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_rd_en;
            // the final tile empties the store, skipped tiles included
            if (r_fin && ((r_state == tde_pkg::S_DECIDE) ||
                          ((r_state == tde_pkg::S_CLASS) &&
                           (n_state == tde_pkg::S_OUT)))) begin
                r_count <= '0;
            end else if ((r_state == tde_pkg::S_DECIDE) && !r_found && w_room) begin
                r_count <= r_count + 1'b1;
            end
            if (w_load) begin
                o_res_valid <= 1'b1;
            end else if (i_pop) begin
                o_res_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tde_pkg::S_IDLE: begin
                r_tile  <= i_job.tile;
                r_pal   <= i_job.pal;
                r_fin   <= i_job.fin;
                r_issue <= '0;
                r_found <= 1'b0;
                r_row   <= '0;
                r_kind  <= tde_pkg::K_SKIP;
            end
            tde_pkg::S_SCAN: begin
                if (w_rd_en) begin
                    r_issue <= r_issue + 1'b1;
                end
                r_pend_idx <= r_issue;
                if (w_hit) begin
                    r_found   <= 1'b1;
                    r_flip    <= w_hit_flip;
                    r_match_j <= r_pend_idx;
                end
            end
            tde_pkg::S_DECIDE: begin
                if (r_found) begin
                    r_kind <= tde_pkg::K_MATCH;
                    r_idx  <= w_idx_hit;
                end else if (w_room) begin
                    r_kind <= tde_pkg::K_NEW;
                    r_idx  <= w_idx_new;
                end else begin
                    r_kind <= tde_pkg::K_FULL;
                end
            end
            tde_pkg::S_OUT: begin
                if (w_load) begin
                    r_row <= r_row + 1'b1;
                end
            end
            default: begin
                r_row <= r_row;
            end
        endcase
        if (w_load) begin
            o_res <= w_res;
        end
    end

    // tile store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if ((r_state == tde_pkg::S_DECIDE) && !r_found && w_room) begin
            mem[r_count[tde_pkg::ADDR_W-1:0]] <= r_tile;
        end
        if (w_rd_en) begin
            r_rdata <= mem[r_issue[tde_pkg::ADDR_W-1:0]];
        end
    end

endmodule

// ===== rtl/tile_dedupe_flip_encoder.sv =====
// ----------------------------------------------------------------------------
// tile_dedupe_flip_encoder
// 8x8 2bpp tile encoder with duplicate and flip matching, planar output
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  rows in  | push / full            | row_pixels, palette_slot, last_tile
//  results  | empty / pop            | map_entry, attribute, planes, flags
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  rows one to seven take one cycle each and never stall while a tile is
//  being collected; the eighth row stalls only while two tiles wait
//  the back end scans one stored tile per cycle through the store's single
//  read port, then emits eight results for a new tile and one otherwise,
//  each waiting until the result slot is free
//  reset is synchronous and clears counters, queues and the tile count;
//  the tile store itself needs no clearing
// ----------------------------------------------------------------------------
module tile_dedupe_flip_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // row requests
    input  logic                           push,
    output logic                           full,
    input  logic [15:0]                    i_row_pixels,
    input  logic [2:0]                     i_palette_slot,
    input  logic                           i_last_tile,
    // result requests
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_map_entry,
    output logic [7:0]                     o_attribute,
    output logic [7:0]                     o_plane_low,
    output logic [7:0]                     o_plane_high,
    output logic                           o_new_tile,
    output logic                           o_skipped,
    output logic                           o_status,
    output logic                           o_last,
    // config requests
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tde_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tde_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tde_pkg::t_cfg r_cfg;
    tde_pkg::t_job w_front_job, w_back_job;
    tde_pkg::t_res w_res;
    logic          w_q_push, w_q_full, w_q_valid, w_q_pop;
    logic          w_res_valid;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tde_pkg::REG_TILE_OFFSET: r_cfg.tile_offset <= i_cfg_data;
                tde_pkg::REG_OBJECT_MODE: r_cfg.object_mode <= i_cfg_data[0];
                tde_pkg::REG_DEDUPE_OFF:  r_cfg.dedupe_off  <= i_cfg_data[0];
                tde_pkg::REG_NO_FLIP_X:   r_cfg.no_flip_x   <= i_cfg_data[0];
                tde_pkg::REG_NO_FLIP_Y:   r_cfg.no_flip_y   <= i_cfg_data[0];
                tde_pkg::REG_NO_FLIP_XY:  r_cfg.no_flip_xy  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // row collection
    tde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_row_pixels   (i_row_pixels),
        .i_palette_slot (i_palette_slot),
        .i_last_tile    (i_last_tile),
        .i_q_full       (w_q_full),
        .o_full         (full),
        .o_q_push       (w_q_push),
        .o_q_job        (w_front_job)
    );

    // finished tiles waiting for the search
    tde_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_back_job)
    );

    // search, store and result generation
    tde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_q_valid),
        .i_job       (w_back_job),
        .o_job_pop   (w_q_pop),
        .i_pop       (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign empty        = !w_res_valid;
    assign o_map_entry  = w_res.map_entry;
    assign o_attribute  = w_res.attribute;
    assign o_plane_low  = w_res.plane_low;
    assign o_plane_high = w_res.plane_high;
    assign o_new_tile   = w_res.new_tile;
    assign o_skipped    = w_res.skipped;
    assign o_status     = w_res.status;
    assign o_last       = w_res.last;

endmodule

// ===== rtl/tde_checker.sv =====
// ----------------------------------------------------------------------------
// tde_checker
// port-level checks for the tile dedupe flip encoder
// ----------------------------------------------------------------------------
module tde_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic empty,
    input logic pop,
    input logic o_new_tile,
    input logic o_skipped,
    input logic o_status,
    input logic o_last
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // a result is only one kind
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> $countones({o_new_tile, o_skipped, o_status}) <= 1)
        else $error("result carries more than one kind");

    // single-result outcomes close their tile
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_new_tile) |-> o_last)
        else $error("single result without last");

    // a waiting result stays until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped before pop");

endmodule

bind tile_dedupe_flip_encoder tde_checker u_tde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_new_tile (o_new_tile),
    .o_skipped  (o_skipped),
    .o_status   (o_status),
    .o_last     (o_last)
);
